// ===== hw/rtl/cps_pkg.sv =====
// Package for the cam/crank phase synchronizer.
// Holds sizes, angle constants, the phase code and the structs shared by
// the input stage, the phase core and the top level. No dependencies.
package cps_pkg;

    // Width of the wrapping reject and sync counters.
    localparam int COUNT_WIDTH  = 16;
    // Bits of the tooth index that the tracker looks at.
    localparam int TOOTH_WIDTH  = 8;

    // Fixed widths of the item and register fields.
    localparam int TOOTH_IN_W   = 8;
    localparam int ANGLE_W      = 12;
    localparam int CYCLE_W      = 13;
    localparam int TOL_W        = 11;
    localparam int COUNT_OUT_W  = 16;
    localparam int DIFF_W       = 14;
    localparam int CFG_DATA_W   = 12;

    // Angles in tenths of a degree.
    localparam int FULL_REV     = 3600;
    localparam int HALF_REV     = 1800;
    localparam int CYCLE_LEN    = 7200;

    typedef enum logic [1:0] {
        PH_NOCRANK = 2'd0,
        PH_WAIT    = 2'd1,
        PH_SYNCED  = 2'd2
    } t_phase;

    // Configuration register indexes.
    typedef enum logic {
        CFG_SYNC_ANGLE = 1'b0,
        CFG_TOLERANCE  = 1'b1
    } t_cfg_addr;

    typedef enum logic {
        CMD_CRANK = 1'b0,
        CMD_CAM   = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                  cmd;
        logic                  crank_synced;
        logic [TOOTH_IN_W-1:0] tooth_index;
        logic [ANGLE_W-1:0]    crank_angle;
    } t_item;

    typedef struct packed {
        logic [ANGLE_W-1:0] cam_sync_angle;
        logic [TOL_W-1:0]   tolerance;
    } t_cfg;

    typedef struct packed {
        t_phase                 phase;
        logic                   revolution;
        logic [CYCLE_W-1:0]     cycle_angle;
        logic [COUNT_WIDTH-1:0] reject_count;
        logic [COUNT_WIDTH-1:0] sync_count;
    } t_result;

endpackage

// ===== hw/rtl/cps_in_stage.sv =====
// Input register of the phase synchronizer.
// Holds one accepted item until the phase core consumes it; uses cps_pkg.
module cps_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cps_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_full,
    output logic           o_load_ok,
    output cps_pkg::t_item o_item
);
    import cps_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  load;

    // A new item may enter when the register is empty or is drained this cycle.
    assign o_load_ok = !r_valid || i_take;
    assign load      = i_valid && o_load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_full = r_valid;
    assign o_item = r_item;

endmodule

// ===== hw/rtl/cps_phase_core.sv =====
// Phase tracking state and its update for one item.
// The state registers double as the result register; uses cps_pkg.
module cps_phase_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_update,
    input  cps_pkg::t_item   i_item,
    input  cps_pkg::t_cfg    i_cfg,
    output cps_pkg::t_result o_result
);
    import cps_pkg::*;

    t_phase                 r_phase,      n_phase;
    logic                   r_rev,        n_rev;
    logic [CYCLE_W-1:0]     r_cycle,      n_cycle;
    logic [TOOTH_WIDTH-1:0] r_prev_tooth, n_prev_tooth;
    logic [COUNT_WIDTH-1:0] r_reject,     n_reject;
    logic [COUNT_WIDTH-1:0] r_sync,       n_sync;

    logic [TOOTH_WIDTH+TOOTH_IN_W-1:0] tooth_ext;
    logic [TOOTH_WIDTH-1:0]            tooth;
    logic signed [DIFF_W-1:0]          diff;
    logic signed [DIFF_W-1:0]          diff_fold;
    logic [DIFF_W-1:0]                 diff_abs;
    logic                              cam_bad;
    logic [CYCLE_W-1:0]                cycle_sum;
    logic [CYCLE_W-1:0]                cycle_wrap;

    assign tooth_ext = {{TOOTH_WIDTH{1'b0}}, i_item.tooth_index};
    assign tooth     = tooth_ext[TOOTH_WIDTH-1:0];

    // Shortest distance on the 360-degree circle; one fold step covers the
    // whole input range.
    always_comb begin
        diff = $signed({2'b00, i_item.crank_angle}) - $signed({2'b00, i_cfg.cam_sync_angle});
        if (diff > DIFF_W'(HALF_REV)) begin
            diff_fold = diff - DIFF_W'(FULL_REV);
        end else if (diff < -DIFF_W'(HALF_REV)) begin
            diff_fold = diff + DIFF_W'(FULL_REV);
        end else begin
            diff_fold = diff;
        end
        diff_abs = diff_fold[DIFF_W-1] ? DIFF_W'(-diff_fold) : DIFF_W'(diff_fold);
        cam_bad  = diff_abs > DIFF_W'(i_cfg.tolerance);
    end

    always_comb begin
        n_phase      = r_phase;
        n_rev        = r_rev;
        n_cycle      = r_cycle;
        n_prev_tooth = r_prev_tooth;
        n_reject     = r_reject;
        n_sync       = r_sync;
        cycle_sum    = '0;
        cycle_wrap   = '0;

        if (i_item.cmd == CMD_CRANK) begin
            if (!i_item.crank_synced) begin
                n_phase = PH_NOCRANK;
                n_rev   = 1'b0;
                n_cycle = '0;
            end else begin
                // The tooth index wrapping to zero marks the gap.
                if (tooth == '0 && r_prev_tooth != '0 && r_phase == PH_SYNCED) begin
                    n_rev = !r_rev;
                end
                n_prev_tooth = tooth;
                if (r_phase == PH_NOCRANK) begin
                    n_phase = PH_WAIT;
                end
                cycle_sum  = {1'b0, i_item.crank_angle}
                           + (n_rev ? CYCLE_W'(FULL_REV) : CYCLE_W'(0));
                cycle_wrap = (cycle_sum >= CYCLE_W'(CYCLE_LEN))
                           ? cycle_sum - CYCLE_W'(CYCLE_LEN) : cycle_sum;
                if (r_phase == PH_SYNCED) begin
                    n_cycle = cycle_wrap;
                end else begin
                    n_cycle = {1'b0, i_item.crank_angle};
                end
            end
        end else begin
            case (r_phase)
                PH_NOCRANK: begin
                end
                PH_SYNCED: begin
                    if (cam_bad) begin
                        n_reject = r_reject + COUNT_WIDTH'(1);
                    end else if (r_rev) begin
                        // Good cam edge in the wrong revolution corrects the phase.
                        n_rev    = 1'b0;
                        n_reject = r_reject + COUNT_WIDTH'(1);
                    end
                end
                default: begin
                    if (cam_bad) begin
                        n_reject = r_reject + COUNT_WIDTH'(1);
                    end else begin
                        n_rev   = 1'b0;
                        n_phase = PH_SYNCED;
                        n_sync  = r_sync + COUNT_WIDTH'(1);
                        n_cycle = {1'b0, i_item.crank_angle};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_NOCRANK;
            r_rev        <= 1'b0;
            r_cycle      <= '0;
            r_prev_tooth <= '0;
            r_reject     <= '0;
            r_sync       <= '0;
        end else if (i_update) begin
            r_phase      <= n_phase;
            r_rev        <= n_rev;
            r_cycle      <= n_cycle;
            r_prev_tooth <= n_prev_tooth;
            r_reject     <= n_reject;
            r_sync       <= n_sync;
        end
    end

    assign o_result.phase        = r_phase;
    assign o_result.revolution   = r_rev;
    assign o_result.cycle_angle  = r_cycle;
    assign o_result.reject_count = r_reject;
    assign o_result.sync_count   = r_sync;

endmodule

// ===== hw/rtl/cam_crank_phase_sync.sv =====
// Top level of the cam/crank engine phase synchronizer.
// Instantiates cps_in_stage and cps_phase_core; uses cps_pkg.
//
//   Channel   Direction  Handshake           Payload
//   input     in         i_valid / o_stall   i_cmd, i_crank_synced, i_tooth_index, i_crank_angle
//   output    out        o_valid / i_stall   o_phase_state, o_revolution, o_cycle_angle,
//                                            o_reject_count, o_sync_count
//   config    in         i_cfg_wr_en         i_cfg_addr, i_cfg_wdata
//
// One item per cycle sustained while i_stall is low; each accepted item passes
// through the input register and then the phase state register, which is also
// the result register, before its result is offered.
// Synchronous active-low reset clears the phase state, counters, configuration and valid flags.
// While the result is stalled, the input register still takes one more item.
module cam_crank_phase_sync (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic                                i_crank_synced,
    input  logic [cps_pkg::TOOTH_IN_W-1:0]      i_tooth_index,
    input  logic [cps_pkg::ANGLE_W-1:0]         i_crank_angle,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_phase_state,
    output logic                                o_revolution,
    output logic [cps_pkg::CYCLE_W-1:0]         o_cycle_angle,
    output logic [cps_pkg::COUNT_OUT_W-1:0]     o_reject_count,
    output logic [cps_pkg::COUNT_OUT_W-1:0]     o_sync_count,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_addr,
    input  logic [cps_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import cps_pkg::*;

    t_item   in_item;
    t_item   stage_item;
    t_cfg    r_cfg;
    t_result result;
    logic    stage_full;
    logic    load_ok;
    logic    advance;
    logic    r_out_valid;

    logic [COUNT_WIDTH+COUNT_OUT_W-1:0] reject_ext;
    logic [COUNT_WIDTH+COUNT_OUT_W-1:0] sync_ext;

    assign in_item.cmd          = i_cmd;
    assign in_item.crank_synced = i_crank_synced;
    assign in_item.tooth_index  = i_tooth_index;
    assign in_item.crank_angle  = i_crank_angle;

    // The staged item moves into the result register when that register is free.
    assign advance = stage_full && (!r_out_valid || !i_stall);
    assign o_stall = !load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_SYNC_ANGLE: r_cfg.cam_sync_angle <= i_cfg_wdata[ANGLE_W-1:0];
                CFG_TOLERANCE:  r_cfg.tolerance      <= i_cfg_wdata[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    cps_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_item    (in_item),
        .i_take    (advance),
        .o_full    (stage_full),
        .o_load_ok (load_ok),
        .o_item    (stage_item)
    );

    cps_phase_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (advance),
        .i_item   (stage_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    assign reject_ext = {{COUNT_OUT_W{1'b0}}, result.reject_count};
    assign sync_ext   = {{COUNT_OUT_W{1'b0}}, result.sync_count};

    assign o_valid        = r_out_valid;
    assign o_phase_state  = result.phase;
    assign o_revolution   = result.revolution;
    assign o_cycle_angle  = result.cycle_angle;
    assign o_reject_count = reject_ext[COUNT_OUT_W-1:0];
    assign o_sync_count   = sync_ext[COUNT_OUT_W-1:0];

endmodule
